// File: hdl/braille_canvas_line_plotter_defines.svh
// Assertion macros for the braille canvas plotter checker
`ifndef BRAILLE_CANVAS_LINE_PLOTTER_DEFINES_SVH
`define BRAILLE_CANVAS_LINE_PLOTTER_DEFINES_SVH

`define BCLP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BCLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bclp_pkg.sv
`default_nettype none
package bclp_pkg;
    localparam int MaxCols = 256;
    localparam int MaxRows = 128;
    localparam int CellCount = MaxCols * MaxRows;
    localparam int AddrW = $clog2(CellCount);
    localparam int ColW = $clog2(MaxCols + 1);
    localparam int RowW = $clog2(MaxRows + 1);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LINE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [0:0] REG_COLS = 1'd0;
    localparam logic [0:0] REG_ROWS = 1'd1;

    localparam logic [1:0] STY_NONE = 2'd0;
    localparam logic [1:0] STY_BOLD = 2'd1;
    localparam logic [1:0] STY_DIM  = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // latch request, init walk
        logic clr_step;  // write zero at clear address, advance
        logic plot_rd;   // issue read of current pixel cell
        logic plot_wr;   // write back merged cell, step walk
        logic rd_issue;  // issue read for read command
        logic done;      // publish result
    } bclp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic at_end;
        logic cap_hit;
        logic [1:0] op;
    } bclp_stat_t;

    function automatic logic [7:0] dot_of(input logic [1:0] py, input logic px);
        logic [7:0] r;
        case ({py, px})
            3'd0: r = 8'h01;
            3'd1: r = 8'h08;
            3'd2: r = 8'h02;
            3'd3: r = 8'h10;
            3'd4: r = 8'h04;
            3'd5: r = 8'h20;
            3'd6: r = 8'h40;
            default: r = 8'h80;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// File: hdl/bclp_ctrl.sv
`default_nettype none
module bclp_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic cfg_clear,
    input  wire bclp_pkg::bclp_stat_t stat,
    output logic busy,
    output bclp_pkg::bclp_cmd_t cmd
);
    import bclp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DEC   = 7'b0000010,
        S_CLR   = 7'b0000100,
        S_PRD   = 7'b0001000,
        S_PWR   = 7'b0010000,
        S_RD    = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   clr_pending_reg, clr_pending_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_pending_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            clr_pending_reg <= clr_pending_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_pending_next = clr_pending_reg;
        cmd = '0;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_clear)
                begin
                    state_next = S_CLR;
                    clr_pending_next = 1'b1;
                end
                else if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (stat.op)
                    OP_CLEAR: state_next = S_CLR;
                    OP_LINE:  state_next = S_PRD;
                    OP_READ:  state_next = S_RD;
                    default:  state_next = S_DONE;
                endcase
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    if (clr_pending_reg)
                    begin
                        clr_pending_next = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_PRD:
            begin
                cmd.plot_rd = 1'b1;
                state_next = S_PWR;
            end
            S_PWR:
            begin
                cmd.plot_wr = 1'b1;
                state_next = (stat.at_end || stat.cap_hit) ? S_DONE : S_PRD;
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.done = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: hdl/bclp_dpath.sv
`default_nettype none
module bclp_dpath (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire bclp_pkg::bclp_cmd_t cmd,
    input  wire logic cfg_we,
    input  wire logic cfg_idx,
    input  wire logic [8:0] cfg_data,
    input  wire logic [1:0] opcode,
    input  wire logic signed [15:0] start_x,
    input  wire logic signed [15:0] start_y,
    input  wire logic signed [15:0] end_x,
    input  wire logic signed [15:0] end_y,
    input  wire logic [7:0] color_pair,
    input  wire logic bold,
    input  wire logic dim,
    input  wire logic [7:0] cell_col,
    input  wire logic [6:0] cell_row,
    output bclp_pkg::bclp_stat_t stat,
    output logic done,
    output logic [7:0] dot_bits,
    output logic [7:0] cell_color,
    output logic [1:0] style,
    output logic [7:0] glyph_byte0,
    output logic [7:0] glyph_byte1,
    output logic [7:0] glyph_byte2,
    output logic truncated,
    output logic cell_valid
);
    import bclp_pkg::*;

    // cell store: dots, color, style packed per entry
    logic [17:0] mem [CellCount];
    logic [17:0] rdata_reg;

    logic [ColW-1:0] cols_reg;
    logic [RowW-1:0] rows_reg;
    logic [1:0]  op_reg;
    logic signed [17:0] x_reg, y_reg, x1_reg, y1_reg, dx_reg, dy_reg, err_reg;
    logic sx_reg, sy_reg;
    logic [12:0] steps_reg, cap_reg;
    logic [7:0] color_reg;
    logic [1:0] sty_reg;
    logic [AddrW-1:0] addr_reg, clr_addr_reg;
    logic inside_reg, rvalid_reg, trunc_reg;
    logic [7:0] dot_reg;

    // pixel address: (py>>2)*cols + (px>>1)
    logic inside_c;
    logic [AddrW:0] idx_c;
    always_comb
    begin
        inside_c = !x_reg[17] && !y_reg[17]
            && (x_reg < $signed({8'd0, cols_reg, 1'b0}))
            && (y_reg < $signed({8'd0, rows_reg, 2'b00}));
        idx_c = (AddrW + 1)'(({3'd0, y_reg[15:2]} * {7'd0, cols_reg})
            + {6'd0, x_reg[15:1]});
    end

    logic signed [18:0] e2;
    assign e2 = {err_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= ColW'(80);
            rows_reg <= RowW'(24);
            clr_addr_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            done <= cmd.done;
            if (cfg_we)
            begin
                if (cfg_idx == REG_COLS)
                    cols_reg <= (cfg_data == 9'd0) ? ColW'(1)
                        : (cfg_data > 9'(MaxCols)) ? ColW'(MaxCols) : ColW'(cfg_data);
                else
                    rows_reg <= (cfg_data[7:0] == 8'd0) ? RowW'(1)
                        : (cfg_data[7:0] > 8'(MaxRows)) ? RowW'(MaxRows)
                        : RowW'(cfg_data[7:0]);
            end
            if (cmd.clr_step)
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode;
            x_reg <= 18'(start_x);
            y_reg <= 18'(start_y);
            x1_reg <= 18'(end_x);
            y1_reg <= 18'(end_y);
            dx_reg <= (end_x > start_x) ? 18'(end_x) - 18'(start_x)
                : 18'(start_x) - 18'(end_x);
            dy_reg <= (end_y > start_y) ? 18'(start_y) - 18'(end_y)
                : 18'(end_y) - 18'(start_y);
            sx_reg <= (start_x < end_x);
            sy_reg <= (start_y < end_y);
            color_reg <= color_pair;
            sty_reg <= bold ? STY_BOLD : (dim ? STY_DIM : STY_NONE);
            steps_reg <= '0;
            cap_reg <= 13'({cols_reg, 3'b000}) + 13'({rows_reg, 4'b0000});
            trunc_reg <= 1'b0;
            rvalid_reg <= ({1'b0, cell_col} < cols_reg) && ({1'b0, cell_row} < rows_reg);
            addr_reg <= AddrW'({7'd0, cell_row} * {6'd0, cols_reg} + {7'd0, cell_col});
        end
        else if (op_reg == OP_LINE && !cmd.plot_rd && !cmd.plot_wr && !cmd.done)
            err_reg <= dx_reg + dy_reg;
        if (cmd.plot_rd)
        begin
            inside_reg <= inside_c && (idx_c < (AddrW + 1)'(CellCount));
            addr_reg <= idx_c[AddrW-1:0];
            dot_reg <= dot_of(y_reg[1:0], x_reg[0]);
        end
        if (cmd.plot_wr)
        begin
            if (!(stat.at_end))
            begin
                if (steps_reg + 1'b1 > cap_reg)
                    trunc_reg <= 1'b1;
                steps_reg <= steps_reg + 1'b1;
                if (e2 >= 19'(dy_reg))
                    x_reg <= sx_reg ? x_reg + 1'b1 : x_reg - 1'b1;
                if (e2 <= 19'(dx_reg))
                    y_reg <= sy_reg ? y_reg + 1'b1 : y_reg - 1'b1;
                err_reg <= err_reg + ((e2 >= 19'(dy_reg)) ? dy_reg : 18'sd0)
                    + ((e2 <= 19'(dx_reg)) ? dx_reg : 18'sd0);
            end
        end
    end

    // memory port: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            mem[clr_addr_reg] <= '0;
        else if (cmd.plot_wr && inside_reg)
            mem[addr_reg] <= {rdata_reg[17:10] | dot_reg, color_reg, sty_reg};
        if (cmd.plot_rd)
            rdata_reg <= mem[idx_c[AddrW-1:0]];
        else if (cmd.rd_issue)
            rdata_reg <= mem[rvalid_reg ? addr_reg : '0];
    end

    assign stat.op = op_reg;
    assign stat.clr_last = (clr_addr_reg == AddrW'(CellCount - 1));
    assign stat.at_end = (x_reg == x1_reg) && (y_reg == y1_reg);
    assign stat.cap_hit = (steps_reg + 1'b1 > cap_reg);

    // result fields are driven only in the done cycle, zero otherwise
    logic rd_ok;
    logic [13:0] code;
    assign rd_ok = done && (op_reg == OP_READ) && rvalid_reg;
    assign code = 14'h2800 + {6'd0, rdata_reg[17:10]};
    assign dot_bits = rd_ok ? rdata_reg[17:10] : 8'd0;
    assign cell_color = rd_ok ? rdata_reg[9:2] : 8'd0;
    assign style = rd_ok ? rdata_reg[1:0] : 2'd0;
    assign glyph_byte0 = rd_ok ? (8'hE0 | {6'd0, code[13:12]}) : 8'd0;
    assign glyph_byte1 = rd_ok ? (8'h80 | {2'd0, code[11:6]}) : 8'd0;
    assign glyph_byte2 = rd_ok ? (8'h80 | {2'd0, code[5:0]}) : 8'd0;
    assign truncated = done && (op_reg == OP_LINE) && trunc_reg;
    assign cell_valid = rd_ok;
endmodule
`default_nettype wire

// File: hdl/braille_canvas_line_plotter.sv
`default_nettype none
// Braille canvas line plotter.
// Requests enter on start when busy is low: opcode clear, line or read plus
// endpoints, color, style and cell address.
// One result per request appears on the output ports for exactly one cycle
// with done high; the receiver cannot stall.
// Clear: sweeps all 32768 cells, one per cycle.
// Line: a decode state, then for each pixel a read and a merge-write of
// the cell store, then a state that publishes the result.
// Read: a decode state, a registered read of the cell, then publish.
// busy drops in the cycle done is high, so the next request can be taken
// there; no new request is taken while one is still in progress.
// Reset and a configuration write while idle start the same clearing
// pass; busy is high meanwhile and no request is taken. cfg_we writes
// canvas_cols (idx 0) or canvas_rows (idx 1, low 8 bits), saturated to range.
// Outputs hold zero in fields that the operation does not produce, and all
// result outputs are zero while done is low.
module braille_canvas_line_plotter (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic busy,
    output logic done,
    input  wire logic cfg_we,
    input  wire logic cfg_idx,
    input  wire logic [8:0] cfg_data,
    input  wire logic [1:0] opcode,
    input  wire logic signed [15:0] start_x,
    input  wire logic signed [15:0] start_y,
    input  wire logic signed [15:0] end_x,
    input  wire logic signed [15:0] end_y,
    input  wire logic [7:0] color_pair,
    input  wire logic bold,
    input  wire logic dim,
    input  wire logic [7:0] cell_col,
    input  wire logic [6:0] cell_row,
    output logic [7:0] dot_bits,
    output logic [7:0] cell_color,
    output logic [1:0] style,
    output logic [7:0] glyph_byte0,
    output logic [7:0] glyph_byte1,
    output logic [7:0] glyph_byte2,
    output logic truncated,
    output logic cell_valid
);
    import bclp_pkg::*;

    bclp_cmd_t  cmd;
    bclp_stat_t stat;

    bclp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .cfg_clear(cfg_we),
        .stat(stat), .busy(busy), .cmd(cmd)
    );

    bclp_dpath u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .opcode(opcode), .start_x(start_x), .start_y(start_y),
        .end_x(end_x), .end_y(end_y), .color_pair(color_pair),
        .bold(bold), .dim(dim), .cell_col(cell_col), .cell_row(cell_row),
        .stat(stat), .done(done), .dot_bits(dot_bits), .cell_color(cell_color),
        .style(style), .glyph_byte0(glyph_byte0), .glyph_byte1(glyph_byte1),
        .glyph_byte2(glyph_byte2), .truncated(truncated), .cell_valid(cell_valid)
    );
endmodule
`default_nettype wire

// File: hdl/bclp_checker.sv
`default_nettype none
`include "braille_canvas_line_plotter_defines.svh"
module bclp_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic truncated,
    input wire logic cell_valid,
    input wire logic [7:0] dot_bits,
    input wire logic [7:0] glyph_byte0
);
    `BCLP_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "no busy after request")
    `BCLP_ASSERT_IMPL(a_done_busy, clk, rst_n, done, !busy, "done while busy")
    `BCLP_ASSERT_IMPL(a_excl, clk, rst_n, done, !(truncated && cell_valid), "truncated on read")
    `BCLP_ASSERT_IMPL(a_glyph, clk, rst_n, done && cell_valid, glyph_byte0 == 8'hE2, "bad glyph")
    `BCLP_ASSERT_IMPL(a_quiet, clk, rst_n, !done, !cell_valid && dot_bits == 8'd0, "idle output")
endmodule
bind braille_canvas_line_plotter bclp_checker u_bclp_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .truncated(truncated), .cell_valid(cell_valid), .dot_bits(dot_bits),
    .glyph_byte0(glyph_byte0)
);
`default_nettype wire
